[rtl/calvs_pkg.sv]
// ----------------------------------------------------------------------------
// calvs_pkg: shared types and constants
// Operation codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package calvs_pkg;

  localparam int SETS_DEF   = 64;
  localparam int WAYS_DEF   = 8;
  localparam int WINDOW_DEF = 4;

  localparam int FUNC_W  = 2;
  localparam int SET_W   = 6;
  localparam int WAY_W   = 3;
  localparam int STAMP_W = 64;
  localparam int PEN_W   = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_TOUCH = 2'd0,
    FN_FILL  = 2'd1,
    FN_INVAL = 2'd2,
    FN_VICT  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_RANK,
    ST_SUM,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic rank;
    logic sum;
    logic write;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_victim;
  } ctl_sts_t;

endpackage

[rtl/calvs_ctrl.sv]
// ----------------------------------------------------------------------------
// calvs_ctrl: sequencer
// Steps each transfer through read and write-back phases, with rank and sum phases between them for victim choice.
// ----------------------------------------------------------------------------
module calvs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_free,
  input  calvs_pkg::ctl_sts_t sts,
  output calvs_pkg::ctl_cmd_t cmd,
  output logic                busy,
  output logic                done
);
  import calvs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = sts.is_victim ? ST_RANK : ST_WRITE;
      end
      ST_RANK: begin
        cmd.rank  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/calvs_dp.sv]
// ----------------------------------------------------------------------------
// calvs_dp: per-set way storage and victim datapath
// Row-wide memories, rank computation, windowed penalty sum, stamp rotation.
// ----------------------------------------------------------------------------
module calvs_dp #(
  parameter int SETS   = calvs_pkg::SETS_DEF,
  parameter int WAYS   = calvs_pkg::WAYS_DEF,
  parameter int WINDOW = calvs_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  calvs_pkg::ctl_cmd_t           cmd,
  output calvs_pkg::ctl_sts_t           sts,
  input  logic [calvs_pkg::FUNC_W-1:0]  in_func,
  input  logic [calvs_pkg::SET_W-1:0]   in_set_index,
  input  logic [calvs_pkg::WAY_W-1:0]   in_way,
  input  logic [calvs_pkg::STAMP_W-1:0] in_now_tick,
  input  logic [calvs_pkg::PEN_W-1:0]   in_miss_latency,
  output logic [calvs_pkg::WAY_W-1:0]   res_way,
  output logic                          res_spared
);
  import calvs_pkg::*;

  localparam int SI_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WI_W = $clog2(WAYS);
  localparam int RK_W = $clog2(WAYS);
  localparam int LEN  = (WINDOW < WAYS - 1) ? WINDOW : (WAYS - 1);
  localparam int SUM_W = PEN_W + 4;

  typedef logic [WAYS-1:0][STAMP_W-1:0] srow_t;
  typedef logic [WAYS-1:0][PEN_W-1:0]   prow_t;

  // row memories; valid bit per set stands for the reset value
  srow_t stamp_mem [SETS];
  prow_t pen_mem   [SETS];
  logic [WAYS-1:0] mark_mem [SETS];
  logic [SETS-1:0] vld_r;

  logic [FUNC_W-1:0]  func_r;
  logic [SET_W-1:0]   set_r;
  logic [WAY_W-1:0]   way_r;
  logic [STAMP_W-1:0] now_r;
  logic [PEN_W-1:0]   lat_r;
  logic               set_ok, way_ok;

  srow_t           st_r, st_nxt, st_rd;
  prow_t           pn_r, pn_rd;
  logic [WAYS-1:0] mk_r, mk_nxt, mk_rd;
  logic            row_vld_r;

  srow_t           ld_st;
  prow_t           ld_pn;
  logic [WAYS-1:0] ld_mk;

  logic [WAYS-1:0][RK_W-1:0] rank_r;
  logic [WAYS-1:0][RK_W-1:0] rank_c;
  logic [WAY_W-1:0] res_way_r;
  logic             res_spared_r;

  assign set_ok = (SET_W'(SETS) > set_r) || (SETS >= (1 << SET_W));
  assign way_ok = (WAY_W'(WAYS) > way_r) || (WAYS >= (1 << WAY_W));
  assign sts.is_victim = (func_t'(func_r) == FN_VICT) && set_ok;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      set_r  <= in_set_index;
      way_r  <= in_way;
      now_r  <= in_now_tick;
      lat_r  <= in_miss_latency;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_rd <= stamp_mem[in_set_index[SI_W-1:0]];
      pn_rd <= pen_mem[in_set_index[SI_W-1:0]];
      mk_rd <= mark_mem[in_set_index[SI_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_vld_r <= 1'b0;
    else if (cmd.load) row_vld_r <= vld_r[in_set_index[SI_W-1:0]];
  end

  // row as read, with touch, fill or invalidate applied to the addressed way
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ld_st[w] = row_vld_r ? st_rd[w] : '0;
      ld_pn[w] = row_vld_r ? pn_rd[w] : '0;
    end
    ld_mk = row_vld_r ? mk_rd : '1;
    if (set_ok && way_ok && func_t'(func_r) != FN_VICT) begin
      if (func_t'(func_r) == FN_INVAL) begin
        ld_st[way_r[WI_W-1:0]] = '0;
        ld_mk[way_r[WI_W-1:0]] = 1'b1;
      end else begin
        ld_st[way_r[WI_W-1:0]] = now_r;
        ld_mk[way_r[WI_W-1:0]] = 1'b0;
      end
      if (func_t'(func_r) == FN_FILL) ld_pn[way_r[WI_W-1:0]] = lat_r;
    end
  end

  // rank: older stamp first, lower way first on equal stamps
  always_comb begin
    for (int a = 0; a < WAYS; a++) begin
      rank_c[a] = '0;
      for (int b = 0; b < WAYS; b++)
        if (b != a && ((st_r[b] < st_r[a]) || (st_r[b] == st_r[a] && b < a)))
          rank_c[a] = rank_c[a] + RK_W'(1);
    end
  end

  // window lookups by rank
  logic [WAY_W-1:0] way_at [WAYS];
  always_comb begin
    for (int k = 0; k < WAYS; k++) begin
      way_at[k] = '0;
      for (int w = 0; w < WAYS; w++)
        if (rank_r[w] == RK_W'(k)) way_at[k] = WAY_W'(w);
    end
  end

  logic [SUM_W-1:0] run;
  logic [RK_W-1:0]  cnt;
  logic             stop;
  always_comb begin
    run  = '0;
    cnt  = '0;
    stop = 1'b0;
    for (int k = 1; k <= LEN; k++) begin
      run = run + SUM_W'(pn_r[way_at[k][WI_W-1:0]]);
      if (!stop && run <= SUM_W'(pn_r[way_at[0][WI_W-1:0]])) cnt = cnt + RK_W'(1);
      else stop = 1'b1;
    end
    if (cnt > RK_W'(LEN - 1)) cnt = RK_W'(LEN - 1);
  end

  always_comb begin
    st_nxt = st_r;
    mk_nxt = mk_r;
    if (cnt != '0 && !mk_r[way_at[0][WI_W-1:0]]) begin
      mk_nxt[way_at[0][WI_W-1:0]] = 1'b1;
      st_nxt[way_at[0][WI_W-1:0]] = st_r[way_at[cnt + RK_W'(1)][WI_W-1:0]];
      for (int k = 2; k <= LEN; k++)
        if (RK_W'(k) <= cnt + RK_W'(1))
          st_nxt[way_at[k][WI_W-1:0]] = st_r[way_at[k-1][WI_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      st_r         <= ld_st;
      pn_r         <= ld_pn;
      mk_r         <= ld_mk;
      res_way_r    <= '0;
      res_spared_r <= 1'b0;
    end
    if (cmd.rank) rank_r <= rank_c;
    if (cmd.sum) begin
      if (mk_r[way_at[0][WI_W-1:0]] || cnt == '0) begin
        res_way_r    <= way_at[0];
        res_spared_r <= 1'b0;
      end else begin
        res_way_r    <= way_at[1];
        res_spared_r <= 1'b1;
      end
      st_r <= st_nxt;
      mk_r <= mk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && set_ok) begin
      stamp_mem[set_r[SI_W-1:0]] <= st_r;
      pen_mem[set_r[SI_W-1:0]]   <= pn_r;
      mark_mem[set_r[SI_W-1:0]]  <= mk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (cmd.write && set_ok) vld_r[set_r[SI_W-1:0]] <= 1'b1;
  end

  assign res_way    = res_way_r;
  assign res_spared = res_spared_r;

endmodule

[rtl/cost_aware_lru_victim_select.sv]
// ----------------------------------------------------------------------------
// cost_aware_lru_victim_select: per-set cost-aware LRU replacement engine
// Touch, fill, invalidate and victim choice over per-way stamps and penalties.
// ----------------------------------------------------------------------------
// Sequence: out_valid rises after the read, write-back and done states for touch,
// fill and invalidate; victim choice adds rank and sum states after the read.
// Transfers are handled one at a time: in_ready stays low until the result is
// moved into the output register, which waits while an earlier result is held.
// Reset: synchronous; per-set valid bits make every way read as stamp 0,
// penalty 0 and marked until the set is first written.
module cost_aware_lru_victim_select #(
  parameter int SETS   = calvs_pkg::SETS_DEF,
  parameter int WAYS   = calvs_pkg::WAYS_DEF,
  parameter int WINDOW = calvs_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [calvs_pkg::FUNC_W-1:0]  in_func,
  input  logic [calvs_pkg::SET_W-1:0]   in_set_index,
  input  logic [calvs_pkg::WAY_W-1:0]   in_way,
  input  logic [calvs_pkg::STAMP_W-1:0] in_now_tick,
  input  logic [calvs_pkg::PEN_W-1:0]   in_miss_latency,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [calvs_pkg::WAY_W-1:0]   out_victim_way,
  output logic                          out_spared_oldest
);
  import calvs_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic busy, done, out_free;
  logic out_valid_r;
  logic [WAY_W-1:0] out_way_r, res_way;
  logic out_sp_r, res_spared;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !busy;

  calvs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_valid && in_ready),
    .out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  calvs_dp #(.SETS(SETS), .WAYS(WAYS), .WINDOW(WINDOW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_func(in_func), .in_set_index(in_set_index), .in_way(in_way),
    .in_now_tick(in_now_tick), .in_miss_latency(in_miss_latency),
    .res_way(res_way), .res_spared(res_spared)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (done) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_way_r <= res_way;
      out_sp_r  <= res_spared;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_victim_way    = out_way_r;
  assign out_spared_oldest = out_sp_r;

endmodule

[rtl/calvs_chk.sv]
// ----------------------------------------------------------------------------
// calvs_chk: port-level checker
// Handshake and result sanity checks bound to the top level.
// ----------------------------------------------------------------------------
module calvs_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [calvs_pkg::WAY_W-1:0] out_victim_way,
  input logic                        out_spared_oldest
);
  import calvs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_victim_way)
      && $stable(out_spared_oldest))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("took a second transfer while busy");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind cost_aware_lru_victim_select calvs_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_victim_way(out_victim_way), .out_spared_oldest(out_spared_oldest)
);

[tb/sv/cost_aware_lru_victim_select_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cost_aware_lru_victim_select_tb: self-checking testbench
// Directed table then random traffic with bursty idling on both sides and
// a long receiver hold-off; every result is compared with an untimed predictor.
// ----------------------------------------------------------------------------
module cost_aware_lru_victim_select_tb;
  import calvs_pkg::*;

  localparam int NSETS   = 64;
  localparam int NWAYS   = 8;
  localparam int NWIN    = 4;
  localparam int NRAND   = 500;
  localparam int WD_LIMIT = 5000;

  typedef struct {
    func_t       fn;
    logic [5:0]  set;
    logic [2:0]  way;
    logic [63:0] tick;
    logic [31:0] lat;
  } op_t;

  typedef struct {
    logic [2:0] victim;
    logic       spared;
  } res_t;

  typedef struct {
    op_t  op;
    logic chk;
    res_t res;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [1:0]  in_func;
  logic [5:0]  in_set_index;
  logic [2:0]  in_way;
  logic [63:0] in_now_tick;
  logic [31:0] in_miss_latency;
  logic out_valid, out_ready;
  logic [2:0] out_victim_way;
  logic out_spared_oldest;

  logic [63:0] stamp_m [NSETS*NWAYS];
  logic [31:0] pen_m   [NSETS*NWAYS];
  logic        mark_m  [NSETS*NWAYS];

  res_t pending_q[$];
  res_t typed_q[$];
  logic typed_chk_q[$];
  int   n_err;
  int   idle_cyc;
  bit   calm;

  cost_aware_lru_victim_select dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_set_index(in_set_index), .in_way(in_way),
    .in_now_tick(in_now_tick), .in_miss_latency(in_miss_latency),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_victim_way(out_victim_way), .out_spared_oldest(out_spared_oldest)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit way_older(int base, int a, int b);
    if (stamp_m[base+a] != stamp_m[base+b]) return stamp_m[base+a] < stamp_m[base+b];
    return a < b;
  endfunction

  function automatic res_t replace_step(op_t op);
    res_t r;
    int base, old, n, i, cnt, len, idx;
    int ord [NWAYS];
    logic [63:0] sum, lim;
    r.victim = '0;
    r.spared = 1'b0;
    base = int'(op.set) * NWAYS;
    if (op.fn == FN_VICT) begin
      old = 0;
      for (int w = 1; w < NWAYS; w++) if (way_older(base, w, old)) old = w;
      r.victim = old[2:0];
      if (mark_m[base+old]) return r;
      n = 0;
      for (int w = 0; w < NWAYS; w++) begin
        if (w == old) continue;
        i = n;
        while (i > 0 && way_older(base, w, ord[i-1])) begin
          ord[i] = ord[i-1];
          i--;
        end
        ord[i] = w;
        n++;
      end
      len = (NWIN < NWAYS-1) ? NWIN : NWAYS-1;
      lim = pen_m[base+old];
      sum = '0;
      cnt = 0;
      while (cnt < len) begin
        sum += pen_m[base+ord[cnt]];
        if (sum > lim) break;
        cnt++;
      end
      if (cnt > len-1) cnt = len-1;
      if (cnt == 0) return r;
      mark_m[base+old] = 1'b1;
      stamp_m[base+old] = stamp_m[base+ord[cnt]];
      for (i = cnt; i > 0; i--) stamp_m[base+ord[i]] = stamp_m[base+ord[i-1]];
      r.victim = ord[0][2:0];
      r.spared = 1'b1;
      return r;
    end
    idx = base + int'(op.way);
    if (op.fn == FN_INVAL) begin
      stamp_m[idx] = '0;
      mark_m[idx] = 1'b1;
    end else begin
      stamp_m[idx] = op.tick;
      mark_m[idx] = 1'b0;
      if (op.fn == FN_FILL) pen_m[idx] = op.lat;
    end
    return r;
  endfunction

  task automatic send(op_t op, logic chk, res_t typed);
    int gap;
    res_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op.fn;
    in_set_index <= op.set;
    in_way <= op.way;
    in_now_tick <= op.tick;
    in_miss_latency <= op.lat;
    do @(posedge clk); while (!in_ready);
    r = replace_step(op);
    pending_q = {pending_q, r};
    typed_chk_q = {typed_chk_q, chk};
    typed_q = {typed_q, typed};
  endtask

  function automatic op_t mk(func_t f, int s, int w, logic [63:0] t, logic [31:0] l);
    op_t o;
    o.fn = f; o.set = s[5:0]; o.way = w[2:0]; o.tick = t; o.lat = l;
    return o;
  endfunction

  // receiver: random stalls, one long hold-off early on
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    repeat (30) @(posedge clk);
    out_ready <= 1'b0;
    n = 0;
    while (n < 60) begin
      @(posedge clk);
      n++;
    end
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t e, t;
    logic c;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected transfer: victim %0d spared %0b",
                                  out_victim_way, out_spared_oldest);
      end else begin
        e = pending_q.pop_front();
        t = typed_q.pop_front();
        c = typed_chk_q.pop_front();
        if (c && (t.victim !== e.victim || t.spared !== e.spared)) begin
          n_err++;
          if (n_err <= 10) $display("table row disagrees with predictor: %0d/%0b vs %0d/%0b",
                                    t.victim, t.spared, e.victim, e.spared);
        end
        if (out_victim_way !== e.victim || out_spared_oldest !== e.spared) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: exp victim %0d spared %0b, got %0d %0b",
                                    e.victim, e.spared, out_victim_way, out_spared_oldest);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WD_LIMIT) begin
      $display("cost_aware_lru_victim_select_tb: done, errors");
      $finish;
    end
  end

  initial begin
    row_t tbl[$];
    row_t rw;
    res_t z, none;
    op_t o;
    int k, s;
    logic [63:0] tk;
    n_err = 0; idle_cyc = 0; calm = 1'b0;
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      stamp_m[i] = '0; pen_m[i] = '0; mark_m[i] = 1'b1;
    end
    rst_n = 1'b0;
    in_valid = 1'b0; in_func = '0; in_set_index = '0; in_way = '0;
    in_now_tick = '0; in_miss_latency = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    none.victim = 0; none.spared = 0;
    z = none;
    // after reset: all marked, stamp 0, way 0 evicted
    rw.op = mk(FN_VICT, 0, 5, 0, 0); rw.chk = 1; rw.res = z; tbl = {tbl, rw};
    rw.op = mk(FN_VICT, 63, 7, '1, '1); rw.chk = 1; tbl = {tbl, rw};
    // set 1: fill all ways, way 0 oldest and expensive -> spared
    for (int w = 0; w < NWAYS; w++) begin
      rw.op = mk(FN_FILL, 1, w, 64'd100 + w, (w == 0) ? 32'd1000 : 32'd10);
      rw.chk = 1; rw.res = none; tbl = {tbl, rw};
    end
    rw.op = mk(FN_VICT, 1, 0, 0, 0); rw.chk = 0; tbl = {tbl, rw};
    rw.op = mk(FN_VICT, 1, 0, 0, 0); rw.chk = 0; tbl = {tbl, rw};
    rw.op = mk(FN_TOUCH, 2, 7, '1, 0); rw.chk = 1; rw.res = none; tbl = {tbl, rw};
    rw.op = mk(FN_FILL, 2, 0, '1, '1); rw.chk = 1; tbl = {tbl, rw};
    rw.op = mk(FN_VICT, 2, 0, 0, 0); rw.chk = 0; tbl = {tbl, rw};
    rw.op = mk(FN_INVAL, 1, 3, 0, 0); rw.chk = 1; tbl = {tbl, rw};
    rw.op = mk(FN_VICT, 1, 0, 0, 0); rw.chk = 1; rw.res.victim = 3; rw.res.spared = 0;
    tbl = {tbl, rw};
    rw.op = mk(FN_TOUCH, 1, 3, 64'd500, 0); rw.chk = 0; tbl = {tbl, rw};
    rw.op = mk(FN_VICT, 1, 0, 0, 0); rw.chk = 0; tbl = {tbl, rw};

    foreach (tbl[i]) send(tbl[i].op, tbl[i].chk, tbl[i].res);

    // random: four hot sets, victim choice most often, then fill, touch and invalidate
    tk = 64'd1000;
    for (k = 0; k < NRAND; k++) begin
      if (k == NRAND - 60) calm = 1'b1;
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
      tk += $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0: o = mk(FN_INVAL, s, $urandom_range(0, 7), {$urandom, $urandom}, $urandom);
        1, 2: o = mk(FN_TOUCH, s, $urandom_range(0, 7),
                     ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : tk, $urandom);
        3, 4, 5: o = mk(FN_FILL, s, $urandom_range(0, 7),
                        ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : tk,
                        ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 400));
        default: o = mk(FN_VICT, s, $urandom_range(0, 7), {$urandom, $urandom}, $urandom);
      endcase
      send(o, 1'b0, none);
    end
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_err == 0) $display("cost_aware_lru_victim_select_tb: done, clean");
    else $display("cost_aware_lru_victim_select_tb: done, errors");
    $finish;
  end

endmodule

[cost_aware_lru_victim_select.f]
rtl/calvs_pkg.sv
rtl/calvs_ctrl.sv
rtl/calvs_dp.sv
rtl/cost_aware_lru_victim_select.sv
rtl/calvs_chk.sv
tb/sv/cost_aware_lru_victim_select_tb.sv
